>>> sv/assert_macros.svh
// Assertion macros used by the deque pointer control (cdq_ctrl).
// Every macro assumes a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cdq_pkg.sv
// Package for the circular deque: field widths, operation codes, CSR map
// and the status struct passed from the pointer control to the top level.
package cdq_pkg;

   localparam int DATA_W           = 32;
   localparam int OP_W             = 3;
   localparam int CFG_W            = 11;
   localparam int DEFAULT_CAPACITY = 1024;

   // CSR map: one 32-bit register per word, index taken from paddr[2].
   localparam int         CSR_ADDR_W       = 3;
   localparam int         CSR_DATA_W       = 32;
   localparam logic [0:0] CSR_CAPACITY_IDX = 1'b0;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

   typedef struct packed {
      logic accepted;
      logic empty;
      logic full;
   } cdq_status_type;

endpackage

>>> sv/cdq_store.sv
// Ring store of the circular deque: one write port, two registered read ports
// with write-to-read forwarding. Depends on cdq_pkg for the data width.
module cdq_store #(
   parameter int DEPTH  = cdq_pkg::DEFAULT_CAPACITY,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [cdq_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr_a,
   input  logic [ADDR_W-1:0]           rd_addr_b,
   output logic [cdq_pkg::DATA_W-1:0]  rd_data_a,
   output logic [cdq_pkg::DATA_W-1:0]  rd_data_b
);
   import cdq_pkg::*;

   logic [DATA_W-1:0] ring_mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // A read at the address being written returns the new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : ring_mem[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : ring_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> sv/cdq_ctrl.sv
// Pointer and count control of the circular deque: head, tail and element
// count registers, wrap arithmetic and store addressing. Depends on cdq_pkg.
`include "assert_macros.svh"

module cdq_ctrl #(
   parameter int CAPACITY = cdq_pkg::DEFAULT_CAPACITY,
   parameter int PTR_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cfg_wr,
   input  logic [CNT_W-1:0]             cap,
   input  logic                         exec,
   input  logic [cdq_pkg::OP_W-1:0]     op,
   output logic                         wr_en,
   output logic [PTR_W-1:0]             wr_addr,
   output logic [PTR_W-1:0]             front_addr,
   output logic [PTR_W-1:0]             rear_addr,
   output cdq_pkg::cdq_status_type      status
);
   import cdq_pkg::*;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [PTR_W-1:0] cap_m1;
   logic [CNT_W-1:0] head_p1, tail_p1;
   logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec, rear_dec;
   logic             full, empty, ok, push_op;

   assign cap_m1   = PTR_W'(cap - CNT_W'(1));
   assign head_p1  = CNT_W'(head_ff) + CNT_W'(1);
   assign tail_p1  = CNT_W'(tail_ff) + CNT_W'(1);
   assign head_inc = (head_p1 >= cap) ? '0 : head_p1[PTR_W-1:0];
   assign tail_inc = (tail_p1 >= cap) ? '0 : tail_p1[PTR_W-1:0];
   assign head_dec = (head_ff == '0) ? cap_m1 : head_ff - PTR_W'(1);
   assign tail_dec = (tail_ff == '0) ? cap_m1 : tail_ff - PTR_W'(1);

   assign full  = (count_ff >= cap);
   assign empty = (count_ff == '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok       = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      unique case (op)
         OP_PUSH_FRONT: begin
            if (!full) begin
               head_in  = head_dec;
               wr_en    = exec;
               wr_addr  = head_dec;
               count_in = count_ff + CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (!full) begin
               tail_in  = tail_inc;
               wr_en    = exec;
               wr_addr  = tail_ff;
               count_in = count_ff + CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (!empty) begin
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (!empty) begin
               tail_in  = tail_dec;
               count_in = count_ff - CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Rear element sits one slot before the updated tail.
   assign rear_dec   = (tail_in == '0) ? cap_m1 : tail_in - PTR_W'(1);
   assign front_addr = head_in;
   assign rear_addr  = rear_dec;

   assign status.accepted = ok;
   assign status.empty    = (count_in == '0);
   assign status.full     = (count_in >= cap);

   assign push_op = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_ptr_range, (CNT_W'(head_ff) < cap) && (CNT_W'(tail_ff) < cap), "pointer beyond capacity")
   `ASSERT_IMPLIES(a_ptr_meet, head_ff == tail_ff, (count_ff == '0) || (count_ff == cap), "pointers meet with partial count")
   `ASSERT_NEXT(a_push_count, exec && !cfg_wr && ok && push_op, count_ff == $past(count_ff) + CNT_W'(1), "accepted push did not grow count")

endmodule

>>> sv/circular_deque.sv
// Top level of the circular deque: input register, CSR port, result register,
// and the instances of cdq_ctrl and cdq_store. Depends on cdq_pkg.
//
// Double-ended queue in a ring store of CAPACITY 32-bit words. Each request
// transaction carries an operation (push front, push back, pop front, pop
// back, query) and a value; each one yields exactly one response transaction
// with the accepted flag, the front and rear elements after the operation
// (with valid flags, zero when empty) and the empty and full flags. A push is
// refused when full, a pop when empty; unknown operation codes change nothing
// and are refused. The capacity CSR at byte address 0 sets how many words are
// in use (only data bits 10:0 are taken; 0 reads back as 1, values above
// CAPACITY as CAPACITY); writing it empties the deque, so write it only while
// no transaction is in flight. Throughput is one transaction per clock while
// the response side does not stall: the request lands in an input register,
// then in the cycle it executes the head, tail and count are updated and the
// new front and rear words are read from the two-read, one-write store (with
// forwarding of the word written in that same cycle) straight into the
// response register. Response stall holds the response register and, once the
// input register is also full, backs up into req_stall. No clearing pass runs
// after reset; store words only reach a response after a push wrote them.
module circular_deque #(
   parameter int CAPACITY = cdq_pkg::DEFAULT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cdq_pkg::OP_W-1:0]          req_operation,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_item_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
   output logic                              rsp_front_valid,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                              rsp_rear_valid,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   // CSR port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cdq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cdq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import cdq_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]      s1_op_ff;
   logic [DATA_W-1:0]    s1_value_ff;

   // Response register (values live in the store's read registers)
   logic                 rsp_valid_ff, rsp_valid_in;
   cdq_status_type       rsp_status_ff;

   // Capacity CSR
   logic [CNT_W-1:0]     cap_ff, cap_in;
   logic [CFG_W-1:0]     cap_wdata;
   logic                 csr_hit, cfg_wr;

   logic                 exec, req_take;
   logic                 wr_en;
   logic [PTR_W-1:0]     wr_addr, front_addr, rear_addr;
   logic [DATA_W-1:0]    front_word, rear_word;
   cdq_status_type       status;

   // ---------------------------------------------------------------------
   // CSR: write on the access phase, clamp capacity to 1..CAPACITY.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY_IDX);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign cap_wdata  = csr_pwdata[CFG_W-1:0];

   always_comb begin
      if (cap_wdata == '0) begin
         cap_in = CNT_W'(1);
      end else if (32'(cap_wdata) > 32'(CAPACITY)) begin
         cap_in = CNT_W'(CAPACITY);
      end else begin
         cap_in = CNT_W'(cap_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CNT_W'(CAPACITY);
      end else if (cfg_wr) begin
         cap_ff <= cap_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(cap_ff) : '0;

   // ---------------------------------------------------------------------
   // Flow control: execute the held request whenever the response register
   // is empty or draining this cycle; stall the request side otherwise.
   // ---------------------------------------------------------------------
   assign exec      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !exec;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (exec) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload and hold it while stalled; register the status on execute.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_operation;
         s1_value_ff <= $unsigned(req_item_value);
      end
      if (exec) begin
         rsp_status_ff <= status;
      end
   end

   // ---------------------------------------------------------------------
   // Pointer control and ring store
   // ---------------------------------------------------------------------
   cdq_ctrl #(
      .CAPACITY (CAPACITY),
      .PTR_W    (PTR_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_wr     (cfg_wr),
      .cap        (cap_ff),
      .exec       (exec),
      .op         (s1_op_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .front_addr (front_addr),
      .rear_addr  (rear_addr),
      .status     (status)
   );

   cdq_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (s1_value_ff),
      .rd_en     (exec),
      .rd_addr_a (front_addr),
      .rd_addr_b (rear_addr),
      .rd_data_a (front_word),
      .rd_data_b (rear_word)
   );

   // ---------------------------------------------------------------------
   // Response: zero the element values when the deque is empty.
   // ---------------------------------------------------------------------
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_status_ff.accepted;
   assign rsp_is_empty    = rsp_status_ff.empty;
   assign rsp_is_full     = rsp_status_ff.full;
   assign rsp_front_valid = !rsp_status_ff.empty;
   assign rsp_rear_valid  = !rsp_status_ff.empty;
   assign rsp_front_value = rsp_status_ff.empty ? '0 : $signed(front_word);
   assign rsp_rear_value  = rsp_status_ff.empty ? '0 : $signed(rear_word);

endmodule

>>> bench/testbench.sv
// Self-checking bench for circular_deque: directed table, then random traffic per capacity.
// Depends on cdq_pkg and the circular_deque RTL; keeps its own mirror of the deque.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   // Operation codes the block must refuse without changing state.
   localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

   // Byte addresses on the CSR port: the capacity register, and the word
   // right after it, which holds no register.
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {CSR_CAPACITY_IDX, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR    = 3'd4;

   localparam int ITEMS_PER_PHASE = 80;
   localparam int PRESSURE_PHASE  = 5;
   localparam int LONG_HOLD       = 80;

   typedef struct packed {
      logic              accepted;
      logic [DATA_W-1:0] front_value;
      logic              front_valid;
      logic [DATA_W-1:0] rear_value;
      logic              rear_valid;
      logic              is_empty;
      logic              is_full;
   } deque_view_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] data;
      logic [CSR_ADDR_W-1:0] addr;
      bit                typed;
      deque_view_type    view;
   } stim_row_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation;
   logic [DATA_W-1:0]     req_item_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_accepted;
   logic [DATA_W-1:0]     rsp_front_value;
   logic                  rsp_front_valid;
   logic [DATA_W-1:0]     rsp_rear_value;
   logic                  rsp_rear_valid;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the deque: ring contents, pointers, fill level, capacity in use.
   logic [DATA_W-1:0] ring_mirror [DEFAULT_CAPACITY];
   int unsigned       front_ptr;
   int unsigned       back_ptr;
   int unsigned       fill_level;
   int unsigned       live_capacity;

   // Views the block still owes us, oldest first.
   deque_view_type awaited_views [$];
   stim_row_type   stim_rows [$];

   int error_count   = 0;
   bit calm          = 1'b0;   // set for the tail of the run: no idling on either side
   bit long_hold_due = 1'b0;   // ask the receiver for one long stall

   circular_deque i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_front_value (rsp_front_value),
      .rsp_front_valid (rsp_front_valid),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_rear_valid  (rsp_rear_valid),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Mirror of the deque
   // ---------------------------------------------------------------------

   function automatic int unsigned step_fwd(int unsigned p);
      return (p + 1 >= live_capacity) ? 0 : p + 1;
   endfunction

   function automatic int unsigned step_back(int unsigned p);
      return (p == 0) ? live_capacity - 1 : p - 1;
   endfunction

   // Valid flags simply follow "not empty"; values read as zero when empty.
   function automatic deque_view_type make_view(logic acc, logic [DATA_W-1:0] front,
                                                logic [DATA_W-1:0] rear, logic empty,
                                                logic full);
      deque_view_type v;
      v.accepted    = acc;
      v.front_value = empty ? '0 : front;
      v.front_valid = !empty;
      v.rear_value  = empty ? '0 : rear;
      v.rear_valid  = !empty;
      v.is_empty    = empty;
      v.is_full     = full;
      return v;
   endfunction

   // Apply one transaction to the mirror and return the view after it.
   function automatic deque_view_type advance_mirror(logic [OP_W-1:0] op,
                                                     logic [DATA_W-1:0] value);
      bit   full;
      bit   empty;
      logic ok;
      full  = fill_level >= live_capacity;
      empty = fill_level == 0;
      ok    = 1'b0;
      case (op)
         OP_PUSH_FRONT: begin
            if (!full) begin
               front_ptr = step_back(front_ptr);
               ring_mirror[front_ptr] = value;
               fill_level++;
               ok = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (!full) begin
               ring_mirror[back_ptr] = value;
               back_ptr = step_fwd(back_ptr);
               fill_level++;
               ok = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (!empty) begin
               front_ptr = step_fwd(front_ptr);
               fill_level--;
               ok = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (!empty) begin
               back_ptr = step_back(back_ptr);
               fill_level--;
               ok = 1'b1;
            end
         end
         OP_QUERY: begin
            ok = 1'b1;
         end
         default: ;
      endcase
      empty = fill_level == 0;
      full  = fill_level >= live_capacity;
      // Only occupied slots are read here, so every read slot was pushed.
      if (empty)
         return make_view(ok, '0, '0, 1'b1, full);
      return make_view(ok, ring_mirror[front_ptr], ring_mirror[step_back(back_ptr)],
                       1'b0, full);
   endfunction

   // A capacity write clamps to 1..DEFAULT_CAPACITY and empties the deque.
   function automatic void load_capacity(logic [CSR_DATA_W-1:0] data);
      int unsigned v;
      v = 32'(data[CFG_W-1:0]);
      if (v == 0)
         v = 1;
      if (v > DEFAULT_CAPACITY)
         v = DEFAULT_CAPACITY;
      live_capacity = v;
      front_ptr     = 0;
      back_ptr      = 0;
      fill_level    = 0;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
      stim_rows.push_back('{ROW_ITEM, op, value, '0, 1'b0, '0});
   endtask

   task automatic add_known(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                            deque_view_type view);
      stim_rows.push_back('{ROW_ITEM, op, value, '0, 1'b1, view});
   endtask

   task automatic add_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      stim_rows.push_back('{ROW_CSR, OP_QUERY, data, addr, 1'b0, '0});
   endtask

   // Offer one transaction, hold it until accepted, then record its view.
   // An optional idle burst comes first; valid never looks at stall.
   task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] value, bit typed,
                            deque_view_type known);
      deque_view_type predicted;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_item_value <= value;
      do @(posedge clock); while (req_stall);
      predicted = advance_mirror(op, value);
      awaited_views.push_back(typed ? known : predicted);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(bit write, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] data, output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_capacity_readback();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, CAPACITY_ADDR, '0, rdata);
      if (rdata !== CSR_DATA_W'(live_capacity)) begin
         $error("capacity: expected %0d, actual %0d", live_capacity, rdata);
         error_count++;
      end
   endtask

   // Drain everything in flight, then write a register and read back the capacity register.
   task automatic write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] unused;
      req_valid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_access(1'b1, addr, data, unused);
      if (addr == CAPACITY_ADDR)
         load_capacity(data);
      // Idle the port between the write and the read.
      @(posedge clock);
      check_capacity_readback();
   endtask

   function automatic logic [OP_W-1:0] pick_op(traffic_mix_type mix);
      int r;
      int push_pct;
      r = $urandom_range(0, 99);
      if (r < 3)
         return OP_W'(OP_RESERVED_FIRST + $urandom_range(0, OP_RESERVED_LAST - OP_RESERVED_FIRST));
      if (r < 10)
         return OP_QUERY;
      push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response side: check each transaction, stall in random bursts
   // ---------------------------------------------------------------------

   task automatic check_view();
      deque_view_type want;
      if (awaited_views.size() == 0) begin
         $error("response transaction with nothing expected");
         error_count++;
         return;
      end
      want = awaited_views.pop_front();
      if (rsp_accepted !== want.accepted) begin
         $error("accepted: expected %0b, actual %0b", want.accepted, rsp_accepted);
         error_count++;
      end
      if (rsp_front_value !== want.front_value) begin
         $error("front_value: expected %h, actual %h", want.front_value, rsp_front_value);
         error_count++;
      end
      if (rsp_front_valid !== want.front_valid) begin
         $error("front_valid: expected %0b, actual %0b", want.front_valid, rsp_front_valid);
         error_count++;
      end
      if (rsp_rear_value !== want.rear_value) begin
         $error("rear_value: expected %h, actual %h", want.rear_value, rsp_rear_value);
         error_count++;
      end
      if (rsp_rear_valid !== want.rear_valid) begin
         $error("rear_valid: expected %0b, actual %0b", want.rear_valid, rsp_rear_valid);
         error_count++;
      end
      if (rsp_is_empty !== want.is_empty) begin
         $error("is_empty: expected %0b, actual %0b", want.is_empty, rsp_is_empty);
         error_count++;
      end
      if (rsp_is_full !== want.is_full) begin
         $error("is_full: expected %0b, actual %0b", want.is_full, rsp_is_full);
         error_count++;
      end
   endtask

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_view();
         // A long hold counts down here, so the sender keeps offering and
         // the block backs up into req_stall.
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side and CSR port
   // ---------------------------------------------------------------------

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] cap_plan [$];
      logic [CSR_DATA_W-1:0] unused;
      traffic_mix_type       mix;
      int                    mix_left;
      int                    n;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_QUERY;
      req_item_value = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      live_capacity  = DEFAULT_CAPACITY;
      front_ptr      = 0;
      back_ptr       = 0;
      fill_level     = 0;
      mix            = MIX_EVEN;
      mix_left       = 0;

      // Directed table. Views are typed in where they are plain to see.
      // Empty deque: query, both pops, a reserved code.
      add_known(OP_QUERY,          32'h5A5A_A5A5, make_view(1'b1, '0, '0, 1'b1, 1'b0));
      add_known(OP_POP_FRONT,      32'h0,         make_view(1'b0, '0, '0, 1'b1, 1'b0));
      add_known(OP_POP_BACK,       32'hFFFF_FFFF, make_view(1'b0, '0, '0, 1'b1, 1'b0));
      add_known(OP_RESERVED_FIRST, 32'h1,         make_view(1'b0, '0, '0, 1'b1, 1'b0));
      // Value extremes at both ends, reserved code on a nonempty deque.
      add_known(OP_PUSH_BACK,  32'h7FFF_FFFF,
                make_view(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_known(OP_PUSH_FRONT, 32'h8000_0000,
                make_view(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_known(OP_RESERVED_LAST, 32'h0,
                make_view(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_item(OP_PUSH_BACK, 32'h1234_5678);
      add_item(OP_QUERY,     32'hDEAD_BEEF);
      add_item(OP_POP_BACK,  32'h0);
      add_known(OP_POP_BACK,  32'h0,
                make_view(1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0));
      add_known(OP_POP_FRONT, 32'h0, make_view(1'b1, '0, '0, 1'b1, 1'b0));
      // Capacity zero is taken as one: full after a single push.
      add_csr(CAPACITY_ADDR, 32'h0);
      add_known(OP_PUSH_FRONT, 32'hFFFF_FFFF,
                make_view(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
      add_known(OP_PUSH_BACK,  32'h1,
                make_view(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
      add_known(OP_RESERVED_LAST, 32'h2,
                make_view(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
      add_known(OP_POP_FRONT,  32'h0, make_view(1'b1, '0, '0, 1'b1, 1'b0));
      // Upper data bits are dropped: this sets capacity three.
      add_csr(CAPACITY_ADDR, 32'hFFFF_F803);
      add_item(OP_PUSH_BACK, 32'd10);
      add_item(OP_PUSH_BACK, 32'd20);
      // A write beyond the register list must leave the contents alone.
      add_csr(SPARE_ADDR, 32'h1);
      add_known(OP_PUSH_FRONT, 32'd5,  make_view(1'b1, 32'd5, 32'd20, 1'b0, 1'b1));
      add_known(OP_PUSH_BACK,  32'd30, make_view(1'b0, 32'd5, 32'd20, 1'b0, 1'b1));
      add_known(OP_POP_BACK,   32'd0,  make_view(1'b1, 32'd5, 32'd10, 1'b0, 1'b0));
      // Oversized capacity clamps to the full store.
      add_csr(CAPACITY_ADDR, 32'hFFFF_FFFF);
      add_known(OP_PUSH_FRONT, 32'h0, make_view(1'b1, '0, '0, 1'b0, 1'b0));
      add_known(OP_POP_BACK,   32'h0, make_view(1'b1, '0, '0, 1'b1, 1'b0));

      // Capacities for the random phases; the last one is drawn at random.
      cap_plan = '{32'd2, 32'd0, 32'd5, 32'hFFFF_F803, 32'd2047, 32'd16, 32'd1, 32'd7,
                   32'd1024, 32'd0};
      cap_plan[cap_plan.size() - 1] = $urandom_range(4, 40);

      // Hold reset, then confirm the capacity comes up at its reset value.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_capacity_readback();

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_register(stim_rows[i].addr, stim_rows[i].data);
         else
            send_item(stim_rows[i].op, stim_rows[i].data, stim_rows[i].typed, stim_rows[i].view);
      end

      // Random phases: runs that lean toward filling or draining, so that
      // full, empty and pointer wrap come up often at every capacity.
      foreach (cap_plan[p]) begin
         write_register(CAPACITY_ADDR, cap_plan[p]);
         if (p == cap_plan.size() - 1)
            calm = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (mix_left == 0) begin
               mix      = traffic_mix_type'($urandom_range(0, 2));
               mix_left = $urandom_range(4, 24);
            end
            mix_left--;
            if (p == PRESSURE_PHASE && n == 20)
               long_hold_due = 1'b1;
            send_item(pick_op(mix), pick_value(), 1'b0, '0);
         end
      end

      // Drop valid, wait for the last views, then allow the pipeline to settle.
      req_valid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> circular_deque.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_store.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
bench/testbench.sv
